// ===== src/hbpwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbpwm_pkg
// Types and codes shared by the H-bridge PWM gate sequencer modules.
// ----------------------------------------------------------------------------
package hbpwm_pkg;

    // Event codes carried by an input item
    typedef enum logic [2:0] {
        OP_OVERFLOW    = 3'd0,
        OP_COMPARE     = 3'd1,
        OP_OVERCURRENT = 3'd2,
        OP_START       = 3'd3,
        OP_STOP        = 3'd4
    } op_t;

    // Bridge modes
    typedef enum logic [1:0] {
        MODE_FWD   = 2'd0,
        MODE_REV   = 2'd1,
        MODE_BRAKE = 2'd2,
        MODE_HIGHZ = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_SPEED_OFFSET = 2'd0;
    localparam logic [1:0] CFG_DUTY_MIN     = 2'd1;
    localparam logic [1:0] CFG_DUTY_MAX     = 2'd2;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] speed;
        logic       direction;
    } hbpwm_in_t;

    typedef struct packed {
        logic       a_high;
        logic       a_low;
        logic       b_high;
        logic       b_low;
        logic       led_zero;
        logic       led_one;
        logic [7:0] duty;
        logic [1:0] active_mode;
    } hbpwm_out_t;

    typedef struct packed {
        logic [7:0] speed_offset;
        logic [7:0] duty_min;
        logic [7:0] duty_max;
    } hbpwm_cfg_t;

    typedef struct packed {
        mode_t      pending_mode;
        mode_t      running_mode;
        logic [7:0] duty_value;
        logic       gate_ah;
        logic       gate_al;
        logic       gate_bh;
        logic       gate_bl;
        logic       led0;
        logic       led1;
    } hbpwm_state_t;

endpackage

// ===== src/hbpwm_event_logic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbpwm_event_logic
// Next-state logic of the bridge: decodes one event item against the
// current state and configuration.
// ----------------------------------------------------------------------------
module hbpwm_event_logic
    import hbpwm_pkg::*;
(
    input  hbpwm_in_t    item,
    input  hbpwm_cfg_t   cfg,
    input  hbpwm_state_t state_cur,
    output hbpwm_state_t state_next
);

    logic [7:0] duty_sum;
    logic [7:0] duty_clamped;

    // Add offset with 8-bit wrap, then clamp (minimum checked first)
    always_comb
    begin
        duty_sum = item.speed + cfg.speed_offset;
        if (duty_sum < cfg.duty_min)
            duty_clamped = cfg.duty_min;
        else if (duty_sum > cfg.duty_max)
            duty_clamped = cfg.duty_max;
        else
            duty_clamped = duty_sum;
    end

    // Apply the event
    always_comb
    begin
        state_next = state_cur;
        case (item.operation)
            OP_OVERFLOW:
            begin
                state_next.running_mode = state_cur.pending_mode;
                case (state_cur.pending_mode)
                    MODE_FWD:
                    begin
                        {state_next.gate_ah, state_next.gate_al,
                         state_next.gate_bh, state_next.gate_bl} = 4'b1001;
                        {state_next.led0, state_next.led1} = 2'b10;
                    end
                    MODE_REV:
                    begin
                        {state_next.gate_ah, state_next.gate_al,
                         state_next.gate_bh, state_next.gate_bl} = 4'b0110;
                        {state_next.led0, state_next.led1} = 2'b01;
                    end
                    MODE_BRAKE:
                    begin
                        {state_next.gate_ah, state_next.gate_al,
                         state_next.gate_bh, state_next.gate_bl} = 4'b0101;
                        {state_next.led0, state_next.led1} = 2'b00;
                    end
                    default:
                    begin
                        {state_next.gate_ah, state_next.gate_al,
                         state_next.gate_bh, state_next.gate_bl} = 4'b0000;
                        {state_next.led0, state_next.led1} = 2'b11;
                    end
                endcase
            end
            OP_COMPARE:
            begin
                // End the drive phase: active high side off, its low side on
                if (state_cur.running_mode == MODE_FWD)
                begin
                    state_next.gate_ah = 1'b0;
                    state_next.gate_al = 1'b1;
                    {state_next.led0, state_next.led1} = 2'b00;
                end
                else if (state_cur.running_mode == MODE_REV)
                begin
                    state_next.gate_bh = 1'b0;
                    state_next.gate_bl = 1'b1;
                    {state_next.led0, state_next.led1} = 2'b00;
                end
            end
            OP_OVERCURRENT:
            begin
                // Float all gates until the next overflow
                {state_next.gate_ah, state_next.gate_al,
                 state_next.gate_bh, state_next.gate_bl} = 4'b0000;
                {state_next.led0, state_next.led1} = 2'b00;
                state_next.running_mode = MODE_HIGHZ;
            end
            OP_START:
            begin
                if (item.speed == 8'd0)
                begin
                    state_next.pending_mode = MODE_BRAKE;
                    state_next.duty_value   = 8'd0;
                end
                else
                begin
                    state_next.pending_mode = item.direction ? MODE_REV : MODE_FWD;
                    state_next.duty_value   = duty_clamped;
                end
            end
            OP_STOP:
            begin
                state_next.pending_mode = MODE_HIGHZ;
            end
            default:
            begin
                state_next = state_cur;
            end
        endcase
    end

endmodule

// ===== src/h_bridge_pwm_gate_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h_bridge_pwm_gate_sequencer
// Four-gate H-bridge drive sequencer: timer events in, gate/LED/duty items out.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register.
// Throughput: one item per cycle while the result stage is not stalled;
//   the event decode is a single short pass.
// Reset: asynchronous; modes go to high-Z, duty to 0, gates and LEDs low,
//   config to offset 0 / min 0 / max 255, both pipeline stages empty.
// ----------------------------------------------------------------------------
module h_bridge_pwm_gate_sequencer
    import hbpwm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  hbpwm_in_t  in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output hbpwm_out_t out_data
);

    hbpwm_cfg_t   cfg_reg;
    hbpwm_state_t state_reg;
    hbpwm_state_t state_next;
    hbpwm_in_t    item_reg;
    logic         item_valid_reg;
    hbpwm_out_t   out_reg;
    logic         out_valid_reg;
    logic         out_free;
    logic         advance;
    logic         accept;

    // Handshake: result stage frees when empty or taken
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = item_valid_reg && out_free;
    assign in_stall  = item_valid_reg && !out_free;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_offset <= 8'd0;
            cfg_reg.duty_min     <= 8'd0;
            cfg_reg.duty_max     <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPEED_OFFSET: cfg_reg.speed_offset <= cfg_data;
                CFG_DUTY_MIN:     cfg_reg.duty_min     <= cfg_data;
                CFG_DUTY_MAX:     cfg_reg.duty_max     <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Hold the accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (accept)
            item_valid_reg <= 1'b1;
        else if (advance)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_data;
    end

    hbpwm_event_logic u_event_logic (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .state_next (state_next)
    );

    // Advance bridge state once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pending_mode <= MODE_HIGHZ;
            state_reg.running_mode <= MODE_HIGHZ;
            state_reg.duty_value   <= 8'd0;
            state_reg.gate_ah      <= 1'b0;
            state_reg.gate_al      <= 1'b0;
            state_reg.gate_bh      <= 1'b0;
            state_reg.gate_bl      <= 1'b0;
            state_reg.led0         <= 1'b0;
            state_reg.led1         <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.a_high      <= state_next.gate_ah;
            out_reg.a_low       <= state_next.gate_al;
            out_reg.b_high      <= state_next.gate_bh;
            out_reg.b_low       <= state_next.gate_bl;
            out_reg.led_zero    <= state_next.led0;
            out_reg.led_one     <= state_next.led1;
            out_reg.duty        <= state_next.duty_value;
            out_reg.active_mode <= state_next.running_mode;
        end
    end

endmodule

// ===== tb/tb_h_bridge_pwm_gate_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_h_bridge_pwm_gate_sequencer
// Self-checking bench for the H-bridge PWM gate sequencer. A queue of timer
// and command events feeds a bursty driver. A local model of the bridge state
// predicts the gate, LED, duty and mode item for every accepted event. A
// monitor with its own stall pattern checks each output item, field by field,
// against the oldest prediction. Phases step through several duty clamp
// settings, the extremes among them, with register writes only while idle.
// ----------------------------------------------------------------------------
module tb_h_bridge_pwm_gate_sequencer;
    import hbpwm_pkg::*;

    localparam int          CLK_PERIOD  = 8;
    localparam int          QUIET_LIMIT = 4000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          MAX_PRINTS  = 30;
    localparam logic [2:0]  OP_LAST_CODE = 3'd7;

    // DUT connections
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_SPEED_OFFSET;
    logic [7:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    hbpwm_in_t  in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    hbpwm_out_t out_data;

    // Local copy of the bridge state and its registers
    hbpwm_cfg_t bridge_cfg;
    mode_t      pend_mode;
    mode_t      run_mode;
    logic [7:0] duty_reg;
    logic [3:0] gate_levels;    // {a_high, a_low, b_high, b_low}
    logic [1:0] led_levels;     // {led_zero, led_one}

    // Events waiting to be driven, and outputs predicted for accepted events
    hbpwm_in_t  event_queue[$];
    hbpwm_out_t predicted_outputs[$];

    int mismatch_count = 0;
    int events_sent = 0;
    int outputs_checked = 0;
    int settings_used = 0;
    int op_seen[8];

    int burst_left = 0;
    int gap_left = 0;
    int style = 0;
    int style_left = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    bit toggle = 1'b0;
    int quiet_cycles = 0;

    h_bridge_pwm_gate_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Return the bridge state to its power-up values
    task automatic reset_bridge_model();
        bridge_cfg.speed_offset = '0;
        bridge_cfg.duty_min     = '0;
        bridge_cfg.duty_max     = 8'hFF;
        pend_mode   = MODE_HIGHZ;
        run_mode    = MODE_HIGHZ;
        duty_reg    = '0;
        gate_levels = '0;
        led_levels  = '0;
    endtask

    // Apply one event to the bridge state and return the resulting output item
    function automatic hbpwm_out_t apply_event(hbpwm_in_t ev);
        hbpwm_out_t res;
        logic [7:0] v;
        case (ev.operation)
            OP_OVERFLOW:
            begin
                run_mode = pend_mode;
                case (run_mode)
                    MODE_FWD:   begin gate_levels = 4'b1001; led_levels = 2'b10; end
                    MODE_REV:   begin gate_levels = 4'b0110; led_levels = 2'b01; end
                    MODE_BRAKE: begin gate_levels = 4'b0101; led_levels = 2'b00; end
                    default:    begin gate_levels = 4'b0000; led_levels = 2'b11; end
                endcase
            end
            OP_COMPARE:
            begin
                // End the drive phase: high side off, low side on
                if (run_mode == MODE_FWD)
                begin
                    gate_levels[3] = 1'b0;
                    gate_levels[2] = 1'b1;
                    led_levels = 2'b00;
                end
                else if (run_mode == MODE_REV)
                begin
                    gate_levels[1] = 1'b0;
                    gate_levels[0] = 1'b1;
                    led_levels = 2'b00;
                end
            end
            OP_OVERCURRENT:
            begin
                gate_levels = 4'b0000;
                led_levels  = 2'b00;
                run_mode    = MODE_HIGHZ;
            end
            OP_START:
            begin
                if (ev.speed == 8'd0)
                begin
                    pend_mode = MODE_BRAKE;
                    duty_reg  = '0;
                end
                else
                begin
                    // Offset wraps in 8 bits; min is checked first, then max
                    v = ev.speed + bridge_cfg.speed_offset;
                    pend_mode = ev.direction ? MODE_REV : MODE_FWD;
                    if (v < bridge_cfg.duty_min)
                        v = bridge_cfg.duty_min;
                    else if (v > bridge_cfg.duty_max)
                        v = bridge_cfg.duty_max;
                    duty_reg = v;
                end
            end
            OP_STOP:
                pend_mode = MODE_HIGHZ;
            default:
                ;
        endcase
        res.a_high      = gate_levels[3];
        res.a_low       = gate_levels[2];
        res.b_high      = gate_levels[1];
        res.b_low       = gate_levels[0];
        res.led_zero    = led_levels[1];
        res.led_one     = led_levels[0];
        res.duty        = duty_reg;
        res.active_mode = run_mode;
        return res;
    endfunction

    task automatic report_error(string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_error($sformatf("output %0d field %s: got 0x%0h, want 0x%0h",
                                   outputs_checked, name, got, want));
    endtask

    task automatic queue_event(logic [2:0] op, logic [7:0] spd, logic dir);
        hbpwm_in_t ev;
        ev.operation = op;
        ev.speed     = spd;
        ev.direction = dir;
        event_queue.push_back(ev);
    endtask

    function automatic logic [7:0] pick_speed();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'd0;
        else if (r == 1)
            return 8'hFF;
        else if (r == 2)
            return 8'd1;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 0;
        else if (r < 9)
            return $urandom_range(1, 6);
        return $urandom_range(10, 24);
    endfunction

    // Drive one register write after the next edge; the model copy follows at once
    task automatic write_reg(logic [1:0] idx, logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_SPEED_OFFSET: bridge_cfg.speed_offset = value;
            CFG_DUTY_MIN:     bridge_cfg.duty_min     = value;
            CFG_DUTY_MAX:     bridge_cfg.duty_max     = value;
            default:          ;
        endcase
    endtask

    task automatic set_config(logic [7:0] offset, logic [7:0] dmin, logic [7:0] dmax);
        write_reg(CFG_SPEED_OFFSET, offset);
        write_reg(CFG_DUTY_MIN, dmin);
        write_reg(CFG_DUTY_MAX, dmax);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Hold until every queued event is accepted and every output has arrived
    task automatic wait_drained();
        do
            @(negedge clk);
        while (event_queue.size() != 0 || in_valid || predicted_outputs.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    // Mostly start/overflow/compare runs with random content, plus noise
    task automatic queue_random(int n);
        int base;
        base = event_queue.size();
        while (event_queue.size() - base < n)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                queue_event(OP_START, pick_speed(), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 3))
                begin
                    queue_event(OP_OVERFLOW, 8'($urandom), 1'($urandom));
                    repeat ($urandom_range(0, 2))
                        queue_event(OP_COMPARE, 8'($urandom), 1'($urandom));
                    if ($urandom_range(0, 9) == 0)
                        queue_event(OP_OVERCURRENT, 8'($urandom), 1'($urandom));
                end
                if ($urandom_range(0, 4) == 0)
                    queue_event(OP_STOP, 8'($urandom), 1'($urandom));
            end
            else
                queue_event(3'($urandom_range(0, OP_LAST_CODE)), 8'($urandom),
                            1'($urandom));
        end
    endtask

    // Driver: offer queued items in bursts; predict each accepted item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predicted_outputs.push_back(apply_event(in_data));
                op_seen[in_data.operation]++;
                events_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (event_queue.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= event_queue.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = pick_gap();
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check accepted output items and drive the stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        hbpwm_out_t want;
        logic       stall_next;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_outputs.size() == 0)
                    report_error("output item arrived with none predicted");
                else
                begin
                    want = predicted_outputs.pop_front();
                    check_field("a_high", 8'(out_data.a_high), 8'(want.a_high));
                    check_field("a_low", 8'(out_data.a_low), 8'(want.a_low));
                    check_field("b_high", 8'(out_data.b_high), 8'(want.b_high));
                    check_field("b_low", 8'(out_data.b_low), 8'(want.b_low));
                    check_field("led_zero", 8'(out_data.led_zero), 8'(want.led_zero));
                    check_field("led_one", 8'(out_data.led_one), 8'(want.led_one));
                    check_field("duty", out_data.duty, want.duty);
                    check_field("active_mode", 8'(out_data.active_mode),
                                8'(want.active_mode));
                end
                outputs_checked++;
            end

            // Pick a new stall style when the run of the current one ends
            if (style_left == 0)
            begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(20, 80);
            end
            style_left--;
            toggle = ~toggle;
            case (style)
                0:       stall_next = 1'b0;
                1:       stall_next = ($urandom_range(0, 3) == 0);
                2:       stall_next = ($urandom_range(0, 9) < 7);
                default: stall_next = toggle;
            endcase

            // Long hold-off so the block fills and stalls its input
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            out_stall <= stall_next;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles, %0d outputs pending",
                         QUIET_LIMIT, predicted_outputs.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Stimulus and phase control
    initial
    begin
        logic [7:0] offs;
        logic [7:0] dmin;
        logic [7:0] dmax;
        reset_bridge_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        settings_used = 1;

        // Mode sequencing at the power-up register values
        queue_event(OP_OVERFLOW, 8'h00, 1'b0);
        queue_event(OP_COMPARE, 8'hFF, 1'b1);
        queue_event(OP_START, 8'hFF, 1'b0);
        queue_event(OP_OVERFLOW, 8'h00, 1'b0);
        queue_event(OP_COMPARE, 8'h00, 1'b0);
        queue_event(OP_OVERFLOW, 8'h00, 1'b0);
        queue_event(OP_OVERCURRENT, 8'h00, 1'b0);
        queue_event(OP_COMPARE, 8'h00, 1'b0);
        queue_event(OP_OVERFLOW, 8'h00, 1'b0);
        queue_event(OP_START, 8'd1, 1'b1);
        queue_event(OP_OVERFLOW, 8'h00, 1'b0);
        queue_event(OP_COMPARE, 8'h00, 1'b0);
        queue_event(OP_START, 8'd0, 1'b1);
        queue_event(OP_OVERFLOW, 8'h00, 1'b0);
        queue_event(OP_COMPARE, 8'h00, 1'b0);
        queue_event(OP_STOP, 8'hFF, 1'b1);
        queue_event(OP_OVERFLOW, 8'h00, 1'b0);
        queue_event(OP_COMPARE, 8'h00, 1'b0);
        for (int c = OP_STOP + 1; c <= OP_LAST_CODE; c++)
            queue_event(c[2:0], 8'hA5, 1'b1);
        wait_drained();

        // Offset wrap and both clamps
        set_config(8'd200, 8'd50, 8'd100);
        queue_event(OP_START, 8'd100, 1'b0);
        queue_event(OP_START, 8'd55, 1'b0);
        queue_event(OP_START, 8'hFF, 1'b1);
        queue_event(OP_START, 8'd0, 1'b0);
        queue_event(OP_START, 8'd56, 1'b1);
        queue_event(OP_OVERFLOW, 8'h00, 1'b0);
        wait_drained();

        // Lower clamp above upper clamp
        set_config(8'd0, 8'd200, 8'd10);
        queue_event(OP_START, 8'd5, 1'b0);
        queue_event(OP_START, 8'd250, 1'b1);
        queue_event(OP_OVERFLOW, 8'h00, 1'b0);
        queue_event(OP_COMPARE, 8'h00, 1'b0);
        wait_drained();

        // Random phases across register settings
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       begin offs = 8'd0;   dmin = 8'd0;   dmax = 8'hFF; end
                1:       begin offs = 8'hFF;  dmin = 8'hFF;  dmax = 8'hFF; end
                2:       begin offs = 8'd0;   dmin = 8'd0;   dmax = 8'd0;  end
                3:       begin offs = 8'hFF;  dmin = 8'd0;   dmax = 8'hFF; end
                4:       begin offs = 8'd128; dmin = 8'd200; dmax = 8'd10; end
                5:       begin offs = 8'd17;  dmin = 8'd40;  dmax = 8'd220; end
                default:
                begin
                    offs = 8'($urandom);
                    dmin = 8'($urandom);
                    dmax = 8'($urandom);
                end
            endcase
            set_config(offs, dmin, dmax);
            if (p == 3)
            begin
                @(negedge clk);
                hold_req = 1'b1;
            end
            queue_random(215);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (predicted_outputs.size() != 0)
            report_error($sformatf("%0d predicted outputs never arrived",
                                   predicted_outputs.size()));

        $display("run covered %0d events: overflow %0d, compare %0d, overcurrent %0d,",
                 events_sent, op_seen[OP_OVERFLOW], op_seen[OP_COMPARE],
                 op_seen[OP_OVERCURRENT]);
        $display("  start %0d, stop %0d, unused %0d; %0d outputs over %0d settings",
                 op_seen[OP_START], op_seen[OP_STOP],
                 events_sent - op_seen[OP_OVERFLOW] - op_seen[OP_COMPARE]
                 - op_seen[OP_OVERCURRENT] - op_seen[OP_START] - op_seen[OP_STOP],
                 outputs_checked, settings_used);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== h_bridge_pwm_gate_sequencer.f =====
src/hbpwm_pkg.sv
src/hbpwm_event_logic.sv
src/h_bridge_pwm_gate_sequencer.sv
tb/tb_h_bridge_pwm_gate_sequencer.sv
